>>> sv/smae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smae_pkg;

   // Default sizes handed to the top level.
   localparam int WINDOW_MAX_DEFAULT = 64;
   localparam int PRICE_BITS_DEFAULT = 32;

   // Width of the window length written on the control port.
   localparam int CFG_BITS = 7;

   // Window length after reset.
   localparam int WINDOW_RESET = 14;

   // EMA weight: floor(2^17 / (N + 1)) in units of 2^-16, 17 bits so that 1.0 fits.
   localparam int WEIGHT_FRAC = 16;
   localparam int WEIGHT_BITS = WEIGHT_FRAC + 1;

   // Quotient bits the divider resolves in one cycle.
   localparam int DIV_STEP = 4;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_MEAN,
      ST_DIV_WEIGHT,
      ST_MUL_OLD,
      ST_MUL_NEW,
      ST_ROUND,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> sv/smae_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one price sample and its restart flag per beat.
interface smae_req_if #(
   parameter int PRICE_BITS = smae_pkg::PRICE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] price;
   logic                  restart;

   modport source (output valid, output price, output restart, input ready);
   modport sink (input valid, input price, input restart, output ready);
endinterface

`default_nettype wire

>>> sv/smae_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Result channel: the window mean and the exponential average per beat.
interface smae_rsp_if #(
   parameter int PRICE_BITS = smae_pkg::PRICE_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] moving_average;
   logic [PRICE_BITS-1:0] exponential_average;

   modport source (output valid, output moving_average, output exponential_average,
                   input ready);
   modport sink (input valid, input moving_average, input exponential_average,
                 output ready);
endinterface

`default_nettype wire

>>> sv/smae_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, a few quotient bits per cycle.
module smae_div #(
   parameter int DIVIDEND_BITS = 38,
   parameter int DIVISOR_BITS  = 7
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output logic                          done,
   output logic [DIVIDEND_BITS-1:0]      quotient
);

   localparam int STEP     = smae_pkg::DIV_STEP;
   localparam int ITERS    = (DIVIDEND_BITS + STEP - 1) / STEP;
   localparam int PAD_BITS = ITERS * STEP;
   localparam int CNT_BITS = $clog2(ITERS + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CNT_BITS-1:0]     cnt_ff;
   logic [PAD_BITS-1:0]     quo_ff;
   logic [DIVISOR_BITS-1:0] rem_ff;
   logic [DIVISOR_BITS-1:0] dvs_ff;

   logic [PAD_BITS-1:0]     quo_in;
   logic [DIVISOR_BITS-1:0] rem_in;

   // One cycle of the recurrence: STEP times, shift in the next dividend bit and subtract when it fits.
   // The register shifts dividend bits out at the top and quotient bits in at the bottom.
   always_comb begin
      logic [DIVISOR_BITS:0] trial;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int k = 0; k < STEP; k++) begin
         trial  = {rem_in, quo_in[PAD_BITS-1]};
         quo_in = {quo_in[PAD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial     = trial - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[DIVISOR_BITS-1:0];
      end
   end

   // Control: busy while iterating, done pulses for one cycle with the quotient ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(ITERS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath of the recurrence.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= PAD_BITS'(dividend);
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[DIVIDEND_BITS-1:0];

endmodule

`default_nettype wire

>>> sv/simple_and_exponential_moving_average_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple and exponential moving average of a price series.
// The req channel takes one beat per sample: an unsigned fixed-point price and a restart
// flag that makes this sample the first of a new series. The rsp channel returns, from the
// N-th sample of a series on, one beat with the truncated mean of the last N samples and the
// exponential average, which is seeded with the first mean and then follows with weight
// 2/(N+1). Earlier samples of a series give no beat. csr_write with csr_window_len sets N
// (0 is taken as 1, values above WINDOW_MAX as WINDOW_MAX) and starts a new series.
// One sample is processed at a time; req.ready is high only while the block is idle.
// The seeding sample passes once through the shared divider (4 quotient bits a cycle), for
// the mean; every later one passes twice, for the mean and then the weight, and then one
// shared multiplier forms the two EMA products, which are summed and rounded. A sample that
// gives no beat only updates the window sum, count and ring before the block is idle again.
// Reset clears the series, the EMA and the output beat; N returns to 14, or to WINDOW_MAX
// if that is smaller. The ring memory needs no clearing since no entry is used before it
// is written in the current series. While the receiver stalls, the block accepts one more
// sample and holds its result back.
module simple_and_exponential_moving_average_top #(
   parameter int WINDOW_MAX = smae_pkg::WINDOW_MAX_DEFAULT,
   parameter int PRICE_BITS = smae_pkg::PRICE_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   smae_req_if.sink                           req,
   smae_rsp_if.source                         rsp,
   input  wire logic                          csr_write,
   input  wire logic [smae_pkg::CFG_BITS-1:0] csr_window_len
);

   localparam int PTR_BITS  = $clog2(WINDOW_MAX);
   localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
   localparam int DVS_BITS  = $clog2(WINDOW_MAX + 2);
   localparam int SUM_BITS  = PRICE_BITS + PTR_BITS;
   localparam int WBITS     = smae_pkg::WEIGHT_BITS;
   localparam int WFRAC     = smae_pkg::WEIGHT_FRAC;
   localparam int DIV_BITS  = (SUM_BITS > WBITS + 1) ? SUM_BITS : WBITS + 1;
   localparam int PROD_BITS = WBITS + PRICE_BITS;
   localparam int CMP_BITS  = (smae_pkg::CFG_BITS > LEN_BITS) ? smae_pkg::CFG_BITS : LEN_BITS;
   localparam int LEN_RESET = (smae_pkg::WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                     : smae_pkg::WINDOW_RESET;
   localparam logic [WBITS-1:0]    WEIGHT_ONE = WBITS'(1 << WFRAC);
   localparam logic [PROD_BITS:0]  ROUND_HALF = (PROD_BITS + 1)'(1 << (WFRAC - 1));
   localparam logic [DIV_BITS-1:0] WEIGHT_NUM = DIV_BITS'(1) << (WFRAC + 1);

   smae_pkg::state_type state_ff, state_in;

   // Series state and configuration.
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [LEN_BITS-1:0]   seen_ff, seen_in;
   logic [PTR_BITS-1:0]   pos_ff, pos_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [PRICE_BITS-1:0] ema_ff, ema_in;
   logic                  seed_ff, seed_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers of the current sample.
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [PRICE_BITS-1:0] mean_ff, mean_in;
   logic [WBITS-1:0]      weight_ff, weight_in;
   logic [PROD_BITS-1:0]  acc_ff, acc_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [PRICE_BITS-1:0] rsp_ma_ff;
   logic [PRICE_BITS-1:0] rsp_ema_ff;

   // Sample ring.
   logic [PRICE_BITS-1:0] ring [WINDOW_MAX];
   logic [PRICE_BITS-1:0] ring_rd_ff;
   logic [PTR_BITS-1:0]   rd_addr;

   logic                  req_accept;
   logic                  out_free;
   logic                  full;
   logic                  update_emit;
   logic [LEN_BITS-1:0]   pos_inc;
   logic [PROD_BITS:0]    ema_total;
   logic [CMP_BITS-1:0]   cfg_wide;
   logic [WBITS-1:0]      mul_a;
   logic [PRICE_BITS-1:0] mul_b;

   logic                  div_start;
   logic [DIV_BITS-1:0]   div_dividend;
   logic [DVS_BITS-1:0]   div_divisor;
   logic                  div_done;
   logic [DIV_BITS-1:0]   div_quotient;

   assign req_accept = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   // Ring slot of the incoming sample: slot zero on restart or when out of the window.
   always_comb begin
      if (req.restart || (LEN_BITS'(pos_ff) >= len_ff)) begin
         rd_addr = '0;
      end else begin
         rd_addr = pos_ff;
      end
   end

   // Window bookkeeping of the update cycle.
   assign full        = (seen_ff >= len_ff);
   assign pos_inc     = LEN_BITS'(pos_ff) + 1'b1;
   assign update_emit = full || (seen_ff + 1'b1 >= len_ff);
   assign ema_total   = {1'b0, acc_ff} + {1'b0, prod_ff} + ROUND_HALF;
   assign cfg_wide    = CMP_BITS'(csr_window_len);

   // Shared multiplier: old EMA times (1 - a), then the price times a.
   always_comb begin
      if (state_ff == smae_pkg::ST_MUL_OLD) begin
         mul_a = WEIGHT_ONE - weight_ff;
         mul_b = ema_ff;
      end else begin
         mul_a = weight_ff;
         mul_b = price_ff;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smae_pkg::ST_IDLE: begin
            if (req_accept) state_in = smae_pkg::ST_UPDATE;
         end
         smae_pkg::ST_UPDATE: begin
            state_in = update_emit ? smae_pkg::ST_DIV_MEAN : smae_pkg::ST_IDLE;
         end
         smae_pkg::ST_DIV_MEAN: begin
            if (div_done) state_in = seed_ff ? smae_pkg::ST_EMIT : smae_pkg::ST_DIV_WEIGHT;
         end
         smae_pkg::ST_DIV_WEIGHT: begin
            if (div_done) state_in = smae_pkg::ST_MUL_OLD;
         end
         smae_pkg::ST_MUL_OLD: state_in = smae_pkg::ST_MUL_NEW;
         smae_pkg::ST_MUL_NEW: state_in = smae_pkg::ST_ROUND;
         smae_pkg::ST_ROUND:   state_in = smae_pkg::ST_EMIT;
         smae_pkg::ST_EMIT: begin
            if (out_free) state_in = smae_pkg::ST_IDLE;
         end
         default: state_in = smae_pkg::ST_IDLE;
      endcase
   end

   // Handshake and divider control.
   always_comb begin
      req.ready    = (state_ff == smae_pkg::ST_IDLE) && !reset;
      div_start    = 1'b0;
      div_dividend = DIV_BITS'(sum_in);
      div_divisor  = DVS_BITS'(len_ff);
      unique case (state_ff)
         smae_pkg::ST_UPDATE: begin
            div_start = update_emit;
         end
         smae_pkg::ST_DIV_MEAN: begin
            div_start    = div_done && !seed_ff;
            div_dividend = WEIGHT_NUM;
            div_divisor  = DVS_BITS'(len_ff) + 1'b1;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Register next values.
   always_comb begin
      len_in       = len_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      ema_in       = ema_ff;
      seed_in      = seed_ff;
      price_in     = price_ff;
      mean_in      = mean_ff;
      weight_in    = weight_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         smae_pkg::ST_IDLE: begin
            if (req_accept) begin
               price_in = req.price;
               pos_in   = rd_addr;
               if (req.restart) begin
                  sum_in  = '0;
                  seen_in = '0;
               end
            end
         end
         smae_pkg::ST_UPDATE: begin
            // The oldest sample leaves the sum once the window is full.
            sum_in  = sum_ff - (full ? SUM_BITS'(ring_rd_ff) : SUM_BITS'(0))
                      + SUM_BITS'(price_ff);
            seen_in = full ? seen_ff : seen_ff + 1'b1;
            pos_in  = (pos_inc >= len_ff) ? '0 : pos_inc[PTR_BITS-1:0];
            seed_in = !full;
         end
         smae_pkg::ST_DIV_MEAN: begin
            if (div_done) begin
               mean_in = div_quotient[PRICE_BITS-1:0];
               if (seed_ff) ema_in = div_quotient[PRICE_BITS-1:0];
            end
         end
         smae_pkg::ST_DIV_WEIGHT: begin
            if (div_done) weight_in = div_quotient[WBITS-1:0];
         end
         smae_pkg::ST_MUL_OLD: begin
            prod_in = mul_a * mul_b;
         end
         smae_pkg::ST_MUL_NEW: begin
            acc_in  = prod_ff;
            prod_in = mul_a * mul_b;
         end
         smae_pkg::ST_ROUND: begin
            ema_in = ema_total[WFRAC +: PRICE_BITS];
         end
         smae_pkg::ST_EMIT: begin
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase

      // A window write clamps N and starts a new series.
      if (csr_write) begin
         if (cfg_wide == '0) begin
            len_in = LEN_BITS'(1);
         end else if (cfg_wide > CMP_BITS'(WINDOW_MAX)) begin
            len_in = LEN_BITS'(WINDOW_MAX);
         end else begin
            len_in = cfg_wide[LEN_BITS-1:0];
         end
         sum_in  = '0;
         seen_in = '0;
         pos_in  = '0;
      end
   end

   // Control and series registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smae_pkg::ST_IDLE;
         len_ff       <= LEN_BITS'(LEN_RESET);
         seen_ff      <= '0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         ema_ff       <= '0;
         seed_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         ema_ff       <= ema_in;
         seed_ff      <= seed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload registers.
   always_ff @(posedge clock) begin
      price_ff  <= price_in;
      mean_ff   <= mean_in;
      weight_ff <= weight_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      if ((state_ff == smae_pkg::ST_EMIT) && out_free) begin
         rsp_ma_ff  <= mean_ff;
         rsp_ema_ff <= ema_ff;
      end
   end

   // Ring memory: read at accept, the new sample written to the same slot in the next cycle, the update state.
   // One sample is in flight at a time, so a read never meets a pending write.
   always_ff @(posedge clock) begin
      ring_rd_ff <= ring[rd_addr];
      if (state_ff == smae_pkg::ST_UPDATE) ring[pos_ff] <= price_ff;
   end

   smae_div #(
      .DIVIDEND_BITS (DIV_BITS),
      .DIVISOR_BITS  (DVS_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.moving_average      = rsp_ma_ff;
   assign rsp.exponential_average = rsp_ema_ff;

   // The sample count never passes the window length.
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= len_ff)
      else $error("sample count above window length");

   // The ring position stays inside the window, which is never empty.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff != '0) && (LEN_BITS'(pos_ff) < len_ff))
      else $error("ring position outside the window");

   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == smae_pkg::ST_DIV_MEAN || state_ff == smae_pkg::ST_DIV_WEIGHT))
      else $error("divider finished outside a divide state");

   // A result beat appears only out of the emit state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == smae_pkg::ST_EMIT))
      else $error("result beat raised outside the emit state");

endmodule

`default_nettype wire
